// ===== hw/rtl/sparse_run_sprite_clip_blit_top_defines.svh =====
// ----------------------------------------------------------------------------
// sparse run sprite clip blit: assertion macros
// shared concurrent assertion forms, clocked on clk, quiet in reset
// ----------------------------------------------------------------------------
`ifndef SPARSE_RUN_SPRITE_CLIP_BLIT_TOP_DEFINES_SVH
`define SPARSE_RUN_SPRITE_CLIP_BLIT_TOP_DEFINES_SVH

// same-cycle implication
`define SRSCB_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("srscb check failed");

// next-cycle implication
`define SRSCB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("srscb check failed");

`endif

// ===== hw/rtl/srscb_pkg.sv =====
// ----------------------------------------------------------------------------
// srscb_pkg
// shared types and constants of the sparse run sprite clip blitter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package srscb_pkg;

    localparam int WORD_W = 16;
    localparam int ADDR_W = 28;
    localparam int PADDR_W = 5;

    // register indexes (byte address bits 4:2)
    localparam logic [2:0] REG_OFFSET_X = 3'd0;
    localparam logic [2:0] REG_OFFSET_Y = 3'd1;
    localparam logic [2:0] REG_DST_WIDTH = 3'd2;
    localparam logic [2:0] REG_DST_HEIGHT = 3'd3;
    localparam logic [2:0] REG_DST_STRIDE = 3'd4;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              first_word;
    } in_t;

    typedef struct packed {
        logic [ADDR_W-1:0] dst_address;
        logic [WORD_W-1:0] pixel;
    } out_t;

    typedef struct packed {
        logic signed [16:0] offset_x;
        logic signed [16:0] offset_y;
        logic [11:0]        dst_width;
        logic [11:0]        dst_height;
        logic [15:0]        dst_stride;
    } cfg_t;

    typedef enum logic [5:0] {
        PH_IDLE    = 6'b000001,
        PH_SIZE_HI = 6'b000010,
        PH_COLUMN  = 6'b000100,
        PH_ROW     = 6'b001000,
        PH_LENGTH  = 6'b010000,
        PH_PIXELS  = 6'b100000
    } phase_t;

endpackage

// ===== hw/rtl/srscb_cfg.sv =====
// ----------------------------------------------------------------------------
// srscb_cfg
// apb register file for offsets and destination geometry
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module srscb_cfg
    import srscb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output cfg_t               cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_OFFSET_X:   cfg_next.offset_x   = pwdata[16:0];
                REG_OFFSET_Y:   cfg_next.offset_y   = pwdata[16:0];
                REG_DST_WIDTH:  cfg_next.dst_width  = pwdata[11:0];
                REG_DST_HEIGHT: cfg_next.dst_height = pwdata[11:0];
                REG_DST_STRIDE: cfg_next.dst_stride = pwdata[15:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_OFFSET_X:   prdata = {{15{cfg_reg.offset_x[16]}}, cfg_reg.offset_x};
            REG_OFFSET_Y:   prdata = {{15{cfg_reg.offset_y[16]}}, cfg_reg.offset_y};
            REG_DST_WIDTH:  prdata = {20'd0, cfg_reg.dst_width};
            REG_DST_HEIGHT: prdata = {20'd0, cfg_reg.dst_height};
            REG_DST_STRIDE: prdata = {16'd0, cfg_reg.dst_stride};
            default:        prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== hw/rtl/srscb_core.sv =====
// ----------------------------------------------------------------------------
// srscb_core
// stream parser state and per-word clip and address logic
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module srscb_core
    import srscb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic step,
    input  in_t  item,
    input  cfg_t cfg,
    output logic produce,
    output out_t result
);

    phase_t            phase_reg, phase_next;
    logic [31:0]       stream_length_reg, stream_length_next;
    logic [31:0]       words_seen_reg, words_seen_next;
    logic [18:0]       run_column_reg, run_column_next;
    logic [15:0]       pixels_left_reg, pixels_left_next;
    logic [ADDR_W-1:0] row_base_reg, row_base_next;
    logic              row_inside_reg, row_inside_next;

    logic [WORD_W-1:0] w;
    logic [31:0]       ws_inc;
    logic [17:0]       row_pos;
    logic              row_ok;
    logic              col_ok;
    logic [ADDR_W-1:0] row_prod;

    assign w      = item.word;
    assign ws_inc = words_seen_reg + 32'd1;

    // row position and its product with the stride
    assign row_pos  = {2'b00, w} + {cfg.offset_y[16], cfg.offset_y};
    assign row_ok   = !row_pos[17] && (row_pos[16:0] < {5'd0, cfg.dst_height});
    assign row_prod = row_pos[11:0] * cfg.dst_stride;

    // column check against both edges
    assign col_ok = !run_column_reg[18] && (run_column_reg[17:0] < {6'd0, cfg.dst_width});

    assign produce = !item.first_word && (phase_reg == PH_PIXELS) && row_inside_reg && col_ok;
    assign result.dst_address = row_base_reg + {16'd0, run_column_reg[11:0]};
    assign result.pixel       = w;

    always_comb
    begin
        phase_next         = phase_reg;
        stream_length_next = stream_length_reg;
        words_seen_next    = words_seen_reg;
        run_column_next    = run_column_reg;
        pixels_left_next   = pixels_left_reg;
        row_base_next      = row_base_reg;
        row_inside_next    = row_inside_reg;
        if (item.first_word)
        begin
            stream_length_next = {16'd0, w};
            words_seen_next    = 32'd1;
            phase_next         = PH_SIZE_HI;
        end
        else
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    phase_next = PH_IDLE;
                end
                PH_SIZE_HI:
                begin
                    stream_length_next = stream_length_reg | {w, 16'd0};
                    words_seen_next    = ws_inc;
                    phase_next         = PH_COLUMN;
                end
                PH_COLUMN:
                begin
                    if (words_seen_reg >= stream_length_reg)
                    begin
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        run_column_next = {3'b000, w} + {{2{cfg.offset_x[16]}}, cfg.offset_x};
                        words_seen_next = ws_inc;
                        phase_next      = PH_ROW;
                    end
                end
                PH_ROW:
                begin
                    row_inside_next = row_ok;
                    row_base_next   = row_ok ? row_prod : '0;
                    words_seen_next = ws_inc;
                    phase_next      = PH_LENGTH;
                end
                PH_LENGTH:
                begin
                    pixels_left_next = w;
                    words_seen_next  = ws_inc;
                    phase_next       = (w == 16'd0) ? PH_COLUMN : PH_PIXELS;
                end
                PH_PIXELS:
                begin
                    run_column_next  = run_column_reg + 19'd1;
                    words_seen_next  = ws_inc;
                    pixels_left_next = pixels_left_reg - 16'd1;
                    if (pixels_left_reg == 16'd1)
                    begin
                        phase_next = PH_COLUMN;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            stream_length_reg <= '0;
            words_seen_reg    <= '0;
            run_column_reg    <= '0;
            pixels_left_reg   <= '0;
            row_base_reg      <= '0;
            row_inside_reg    <= 1'b0;
        end
        else if (step)
        begin
            phase_reg         <= phase_next;
            stream_length_reg <= stream_length_next;
            words_seen_reg    <= words_seen_next;
            run_column_reg    <= run_column_next;
            pixels_left_reg   <= pixels_left_next;
            row_base_reg      <= row_base_next;
            row_inside_reg    <= row_inside_next;
        end
    end

endmodule

// ===== hw/rtl/sparse_run_sprite_clip_blit_top.sv =====
// ----------------------------------------------------------------------------
// sparse_run_sprite_clip_blit_top: sparse run sprite clipper and blitter
// a kept pixel passes the input register, then the result register, to out_valid
// throughput: one word per cycle unless out_ready stalls; single parse stage
// reset: asynchronous rst_n clears parser state, config registers and both valids
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sparse_run_sprite_clip_blit_top_defines.svh"

module sparse_run_sprite_clip_blit_top
    import srscb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // stream word channel
    input  logic               in_valid,
    output logic               in_ready,
    input  in_t                in_data,
    // pixel write channel
    output logic               out_valid,
    input  logic               out_ready,
    output out_t               out_data,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    // input register: holds one accepted word until the parse stage takes it
    logic s1_valid_reg, s1_valid_next;
    in_t  s1_reg;

    // result register: one pending pixel write
    logic out_valid_reg, out_valid_next;
    out_t out_data_reg;

    cfg_t cfg;
    logic advance;
    logic produce;
    out_t result;

    // word leaves the input register whenever the result slot is free or drains
    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    // new word may enter while the previous one moves on in the same cycle
    assign in_ready = !s1_valid_reg || advance;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    srscb_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // parser, clip test and address generation in one pass
    srscb_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .item    (s1_reg),
        .cfg     (cfg),
        .produce (produce),
        .result  (result)
    );

    always_comb
    begin
        if (in_valid && in_ready)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_comb
    begin
        if (advance)
        begin
            // words that drop or carry headers leave the slot empty
            out_valid_next = produce;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_reg <= in_data;
        end
        if (advance && produce)
        begin
            out_data_reg <= result;
        end
    end

    // accepted word always lands in the input register
    `SRSCB_ASSERT_NEXT(a_in_capture, in_valid && in_ready, s1_valid_reg)
    // a held word stays put while the result side is blocked
    `SRSCB_ASSERT_NEXT(a_s1_hold, s1_valid_reg && !advance, s1_valid_reg && $stable(s1_reg))
    // a kept pixel carries the word that produced it
    `SRSCB_ASSERT_NEXT(a_pixel_match, advance && produce,
        out_valid_reg && (out_data_reg.pixel == $past(s1_reg.word)))
    // a pixel never appears without a parse step behind it
    `SRSCB_ASSERT_NOW(a_out_source, $rose(out_valid_reg), $past(advance))

endmodule
